// ===== hdl/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dtq_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_BITS_DEF  = 32;

    localparam int ID_W   = 4;
    localparam int VAL_W  = 32;
    localparam int LAZY_W = 16;
    localparam int REM_W  = 31;

    localparam logic [LAZY_W-1:0] LAZY_RESET = 16'd300;
    localparam logic [REM_W-1:0]  REM_MAX    = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ARM    = 2'd1,
        CMD_DISARM = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_EXPIRED   = 3'd0,
        KIND_TICK_DONE = 3'd1,
        KIND_ARMED     = 3'd2,
        KIND_SKIPPED   = 3'd3,
        KIND_DISARMED  = 3'd4,
        KIND_QUERY     = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ARM_RD,
        ST_ARM_DIFF,
        ST_ARM_DEC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]       command;
        logic [ID_W-1:0]  timer_id;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       result_kind;
        logic [ID_W-1:0]  result_timer;
        logic [REM_W-1:0] remaining_ms;
        logic             none_armed;
        logic             last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/dtq_min_scan.sv =====
// ----------------------------------------------------------------------------
// dtq_min_scan
// Running minimum over a stream of biased deadline keys, one slot per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_min_scan import dtq_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_clear,
    input  wire logic                          i_valid,
    input  wire logic [$clog2(NUM_TIMERS)-1:0] i_slot,
    input  wire logic                          i_armed,
    input  wire logic                          i_due_only,
    input  wire logic [TIME_BITS-1:0]          i_key,
    output logic                               o_found,
    output logic [$clog2(NUM_TIMERS)-1:0]      o_slot,
    output logic [TIME_BITS-1:0]               o_key
);

    localparam int AW = $clog2(NUM_TIMERS);
    localparam logic [TIME_BITS-1:0] TSIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

    logic                 r_found;
    logic                 n_found;
    logic [AW-1:0]        r_slot;
    logic [AW-1:0]        n_slot;
    logic [TIME_BITS-1:0] r_key;
    logic [TIME_BITS-1:0] n_key;
    logic                 take;

    // A key at the sign point is exactly due; strict less keeps the lower slot on ties.
    always_comb begin
        take    = i_valid && i_armed && (!i_due_only || i_key <= TSIGN)
                  && (!r_found || i_key < r_key);
        n_found = r_found;
        n_slot  = r_slot;
        n_key   = r_key;
        if (i_clear) begin
            n_found = 1'b0;
        end else if (take) begin
            n_found = 1'b1;
            n_slot  = i_slot;
            n_key   = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
        r_slot <= n_slot;
        r_key  <= n_key;
    end

    assign o_found = r_found;
    assign o_slot  = r_slot;
    assign o_key   = r_key;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> !o_found)
        else $error("scan minimum survived a clear");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> (32'(o_slot) < NUM_TIMERS))
        else $error("scan minimum points past the last slot");

endmodule

`default_nettype wire

// ===== hdl/deadline_timer_queue_top.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_queue_top
// One-shot timer set with a deadline memory, lazy re-arm, nearest-deadline
// query and ordered expiry on every tick.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | beat
//  --------+-----------+------------------------+--------------------------
//  in      | input     | i_in_valid/o_in_ready  | t_in_item command
//  out     | output    | o_out_valid/i_out_ready| t_out_item result
//  cfg     | input     | i_cfg_valid/o_cfg_ready| lazy_window, 16 bits
//
// An arm does one read-modify-write of the deadline memory; a disarm does not touch
// it and only clears the armed flag. A query makes one memory read per slot into a
// single comparator. A tick runs one full scan per result. Reset needs no clearing
// pass: armed flags live in flip-flops. A stalled output holds the sequencer in its
// emit step.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_queue_top import dtq_pkg::*; #(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [LAZY_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(NUM_TIMERS);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int IW = (AW > ID_W) ? AW : ID_W;
    localparam int EW = (TIME_BITS > VAL_W) ? TIME_BITS : VAL_W;
    localparam int RW = (TIME_BITS > REM_W) ? TIME_BITS : REM_W;
    localparam logic [TIME_BITS-1:0] TSIGN    = {1'b1, {(TIME_BITS-1){1'b0}}};
    localparam logic [CW-1:0]        SCAN_END = CW'(NUM_TIMERS);

    function automatic t_out_item mk_res(t_kind kind, logic [ID_W-1:0] timer,
                                         logic [REM_W-1:0] rem, logic none,
                                         logic last);
        t_out_item res;
        res.result_kind  = kind;
        res.result_timer = timer;
        res.remaining_ms = rem;
        res.none_armed   = none;
        res.last         = last;
        return res;
    endfunction

    t_state                r_state;
    t_state                n_state;
    logic [TIME_BITS-1:0]  r_now;
    logic [TIME_BITS-1:0]  n_now;
    logic [NUM_TIMERS-1:0] r_armed;
    logic [NUM_TIMERS-1:0] n_armed;
    logic [LAZY_W-1:0]     r_lazy;
    logic [LAZY_W-1:0]     n_lazy;
    t_cmd                  r_cmd;
    t_cmd                  n_cmd;
    logic [ID_W-1:0]       r_id;
    logic [ID_W-1:0]       n_id;
    logic [TIME_BITS-1:0]  r_key;
    logic [TIME_BITS-1:0]  n_key;
    logic [TIME_BITS-1:0]  r_diff;
    logic [TIME_BITS-1:0]  n_diff;
    logic [CW-1:0]         r_rd_idx;
    logic [CW-1:0]         n_rd_idx;
    logic                  r_rd_vld;
    logic                  n_rd_vld;
    logic [AW-1:0]         r_rd_slot;
    logic [AW-1:0]         n_rd_slot;
    logic [TIME_BITS-1:0]  r_rdata;
    t_out_item             r_res;
    t_out_item             n_res;
    logic                  r_more;
    logic                  n_more;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out_item             r_out_data;
    t_out_item             n_out_data;
    logic [TIME_BITS-1:0]  r_mem [NUM_TIMERS];

    logic                  in_accept;
    logic [IW-1:0]         in_id_ext;
    logic [AW-1:0]         in_idx;
    logic                  in_ok;
    logic [IW-1:0]         id_ext;
    logic [AW-1:0]         slot_idx;
    logic                  slot_ok;
    logic [EW-1:0]         val_ext;
    logic [TIME_BITS-1:0]  val_t;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic                  scan_clear;
    logic [TIME_BITS-1:0]  scan_key;
    logic                  scan_found;
    logic [AW-1:0]         scan_slot;
    logic [TIME_BITS-1:0]  scan_best;
    logic [IW-1:0]         scan_slot_ext;
    logic [TIME_BITS-1:0]  rel;
    logic [RW-1:0]         rel_ext;
    logic [REM_W-1:0]      rem;
    logic [TIME_BITS-1:0]  mag;
    logic                  out_free;

    assign in_accept   = i_in_valid && o_in_ready;
    assign in_id_ext   = IW'(i_in_data.timer_id);
    assign in_idx      = in_id_ext[AW-1:0];
    assign in_ok       = 32'(i_in_data.timer_id) < NUM_TIMERS;
    assign id_ext      = IW'(r_id);
    assign slot_idx    = id_ext[AW-1:0];
    assign slot_ok     = 32'(r_id) < NUM_TIMERS;
    assign val_ext     = EW'(i_in_data.value);
    assign val_t       = val_ext[TIME_BITS-1:0];
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Biased offset from now: an unsigned compare then orders deadlines with wraparound.
    assign scan_key      = (r_rdata - r_now) ^ TSIGN;
    assign scan_slot_ext = IW'(scan_slot);
    assign rel           = scan_best ^ TSIGN;
    assign rel_ext       = RW'(rel);
    assign mag           = r_diff[TIME_BITS-1] ? (TIME_BITS'(0) - r_diff) : r_diff;

    always_comb begin
        if (rel == '0 || rel[TIME_BITS-1]) begin
            rem = '0;
        end else if (rel_ext > RW'(REM_MAX)) begin
            rem = REM_MAX;
        end else begin
            rem = rel_ext[REM_W-1:0];
        end
    end

    assign rd_addr = (r_state == ST_SCAN) ? r_rd_idx[AW-1:0] : slot_idx;

    always_comb begin
        n_state     = r_state;
        n_now       = r_now;
        n_armed     = r_armed;
        n_lazy      = r_lazy;
        n_cmd       = r_cmd;
        n_id        = r_id;
        n_key       = r_key;
        n_diff      = r_diff;
        n_rd_idx    = r_rd_idx;
        n_rd_vld    = (r_state == ST_SCAN) && (r_rd_idx != SCAN_END);
        n_rd_slot   = r_rd_idx[AW-1:0];
        n_res       = r_res;
        n_more      = r_more;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        mem_we      = 1'b0;

        if (i_cfg_valid) begin
            n_lazy = i_cfg_data;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_cmd  = t_cmd'(i_in_data.command);
                    n_id   = i_in_data.timer_id;
                    n_more = 1'b0;
                    case (t_cmd'(i_in_data.command))
                        CMD_TICK: begin
                            n_now    = val_t;
                            n_rd_idx = '0;
                            n_state  = ST_SCAN;
                        end
                        CMD_QUERY: begin
                            n_rd_idx = '0;
                            n_state  = ST_SCAN;
                        end
                        CMD_ARM: begin
                            n_key = r_now + val_t;
                            if (in_ok) begin
                                n_state = ST_ARM_RD;
                            end else begin
                                n_res   = mk_res(KIND_SKIPPED, i_in_data.timer_id,
                                                 '0, 1'b0, 1'b1);
                                n_state = ST_EMIT;
                            end
                        end
                        CMD_DISARM: begin
                            if (in_ok) begin
                                n_armed[in_idx] = 1'b0;
                            end
                            n_res   = mk_res(KIND_DISARMED, i_in_data.timer_id,
                                             '0, 1'b0, 1'b1);
                            n_state = ST_EMIT;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_rd_idx != SCAN_END) begin
                    n_rd_idx = r_rd_idx + CW'(1);
                end else if (!r_rd_vld) begin
                    // The last slot has passed the comparator.
                    n_state = ST_EMIT;
                    if (r_cmd == CMD_TICK) begin
                        if (scan_found) begin
                            n_armed[scan_slot] = 1'b0;
                            n_res  = mk_res(KIND_EXPIRED, scan_slot_ext[ID_W-1:0],
                                            '0, 1'b0, 1'b0);
                            n_more = 1'b1;
                        end else begin
                            n_res  = mk_res(KIND_TICK_DONE, '0, '0, 1'b0, 1'b1);
                            n_more = 1'b0;
                        end
                    end else begin
                        n_res = mk_res(KIND_QUERY, '0, scan_found ? rem : '0,
                                       !scan_found, 1'b1);
                    end
                end
            end
            ST_ARM_RD: begin
                n_state = ST_ARM_DIFF;
            end
            ST_ARM_DIFF: begin
                n_diff  = r_key - r_rdata;
                n_state = ST_ARM_DEC;
            end
            ST_ARM_DEC: begin
                n_state = ST_EMIT;
                if (slot_ok && r_armed[slot_idx] && mag < TIME_BITS'(r_lazy)) begin
                    n_res = mk_res(KIND_SKIPPED, r_id, '0, 1'b0, 1'b1);
                end else begin
                    mem_we            = 1'b1;
                    n_armed[slot_idx] = 1'b1;
                    n_res             = mk_res(KIND_ARMED, r_id, '0, 1'b0, 1'b1);
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    if (r_more) begin
                        n_rd_idx = '0;
                        n_state  = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign scan_clear = (n_state == ST_SCAN) && (r_state != ST_SCAN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_now       <= '0;
            r_armed     <= '0;
            r_lazy      <= LAZY_RESET;
            r_rd_idx    <= '0;
            r_rd_vld    <= 1'b0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_now       <= n_now;
            r_armed     <= n_armed;
            r_lazy      <= n_lazy;
            r_rd_idx    <= n_rd_idx;
            r_rd_vld    <= n_rd_vld;
            r_more      <= n_more;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_id       <= n_id;
        r_key      <= n_key;
        r_diff     <= n_diff;
        r_rd_slot  <= n_rd_slot;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    // Commands run one at a time and an arm writes only in its last step,
    // so a read never meets a write in flight to the same entry.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[slot_idx] <= r_key;
        end
        r_rdata <= r_mem[rd_addr];
    end

    dtq_min_scan #(
        .NUM_TIMERS (NUM_TIMERS),
        .TIME_BITS  (TIME_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (scan_clear),
        .i_valid    (r_rd_vld),
        .i_slot     (r_rd_slot),
        .i_armed    (r_armed[r_rd_slot]),
        .i_due_only (r_cmd == CMD_TICK),
        .i_key      (scan_key),
        .o_found    (scan_found),
        .o_slot     (scan_slot),
        .o_key      (scan_best)
    );

    a_idx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_idx <= SCAN_END)
        else $error("scan read index ran past the last slot");

    a_expired_disarmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_rd_idx == SCAN_END && !r_rd_vld
         && r_cmd == CMD_TICK && scan_found)
        |=> !r_armed[$past(scan_slot)])
        else $error("expired timer still armed after its report");

    a_only_expiry_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last)
        |-> (o_out_data.result_kind == KIND_EXPIRED))
        else $error("a result other than an expiry left its command open");

endmodule

`default_nettype wire

// ===== tb/sv/dtq_checker.sv =====
// ----------------------------------------------------------------------------
// dtq_checker
// Watches the command, result and lazy window channels of the deadline timer
// queue. It keeps its own copy of the timer slots, works out the result beats
// of every accepted command, and compares each result beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module dtq_checker import dtq_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_in_ready,
    input  wire t_in_item          i_in_data,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_ready,
    input  wire t_out_item         i_out_data,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [LAZY_W-1:0] i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_results,
    output int                     o_expired
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = NUM_TIMERS_DEF;
    localparam logic [VAL_W-1:0] SIGN_BIT = 32'h8000_0000;

    logic [VAL_W-1:0]  now_ms;
    logic [SLOTS-1:0]  slot_armed;
    logic [VAL_W-1:0]  slot_deadline [SLOTS];
    logic [LAZY_W-1:0] lazy_ms;
    t_out_item         due_results [$];
    int                mismatches = 0;
    int                seen_results = 0;
    int                seen_expired = 0;

    // Biasing the wrapped offset by the sign bit lets a plain unsigned compare
    // order deadlines, with overdue timers below SIGN_BIT.
    function automatic logic [VAL_W-1:0] order_key(input int s);
        return (slot_deadline[s] - now_ms) ^ SIGN_BIT;
    endfunction

    function automatic int nearest_slot(input bit due_only);
        int               best;
        logic [VAL_W-1:0] best_key;
        logic [VAL_W-1:0] key;
        best = -1;
        best_key = '0;
        for (int s = 0; s < SLOTS; s++) begin
            if (!slot_armed[s]) continue;
            key = order_key(s);
            if (due_only && key > SIGN_BIT) continue;
            if (best < 0 || key < best_key) begin
                best = s;
                best_key = key;
            end
        end
        return best;
    endfunction

    function automatic void push_result(input t_kind kind, input int slot,
                                        input logic [REM_W-1:0] rem,
                                        input bit none, input bit fin);
        t_out_item r;
        r.result_kind  = kind;
        r.result_timer = slot[ID_W-1:0];
        r.remaining_ms = rem;
        r.none_armed   = none;
        r.last         = fin;
        due_results.push_back(r);
    endfunction

    function automatic void predict_command(input t_in_item item);
        int               s;
        logic [VAL_W-1:0] target;
        logic [VAL_W-1:0] diff;
        logic [VAL_W-1:0] span;
        logic [VAL_W-1:0] rel;
        case (item.command)
            CMD_TICK: begin
                now_ms = item.value;
                s = nearest_slot(1'b1);
                while (s >= 0) begin
                    slot_armed[s] = 1'b0;
                    push_result(KIND_EXPIRED, s, '0, 1'b0, 1'b0);
                    s = nearest_slot(1'b1);
                end
                push_result(KIND_TICK_DONE, 0, '0, 1'b0, 1'b1);
            end
            CMD_ARM: begin
                s = int'(item.timer_id);
                target = now_ms + item.value;
                span = '1;
                if (slot_armed[s]) begin
                    diff = target - slot_deadline[s];
                    span = diff[VAL_W-1] ? -diff : diff;
                end
                if (slot_armed[s] && span < lazy_ms) begin
                    push_result(KIND_SKIPPED, s, '0, 1'b0, 1'b1);
                end else begin
                    slot_deadline[s] = target;
                    slot_armed[s] = 1'b1;
                    push_result(KIND_ARMED, s, '0, 1'b0, 1'b1);
                end
            end
            CMD_DISARM: begin
                s = int'(item.timer_id);
                slot_armed[s] = 1'b0;
                push_result(KIND_DISARMED, s, '0, 1'b0, 1'b1);
            end
            default: begin
                s = nearest_slot(1'b0);
                if (s < 0) begin
                    push_result(KIND_QUERY, 0, '0, 1'b1, 1'b1);
                end else begin
                    rel = slot_deadline[s] - now_ms;
                    // An overdue deadline reads as zero remaining.
                    push_result(KIND_QUERY, 0,
                                (rel != 0 && !rel[VAL_W-1]) ? rel[REM_W-1:0] : '0,
                                1'b0, 1'b1);
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            now_ms = '0;
            slot_armed = '0;
            lazy_ms = LAZY_RESET;
            due_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) lazy_ms = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_command(i_in_data);
            if (i_out_valid && i_out_ready) begin
                seen_results++;
                if (i_out_data.result_kind == KIND_EXPIRED) seen_expired++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("dtq_checker: unexpected result kind %0d timer %0d",
                                 i_out_data.result_kind, i_out_data.result_timer);
                end else begin
                    want = due_results.pop_front();
                    if (want.result_kind !== i_out_data.result_kind
                        || want.result_timer !== i_out_data.result_timer
                        || want.remaining_ms !== i_out_data.remaining_ms
                        || want.none_armed !== i_out_data.none_armed
                        || want.last !== i_out_data.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("dtq_checker: result %0d expected kind %0d timer %0d rem %0d none %0b last %0b",
                                     seen_results, want.result_kind, want.result_timer,
                                     want.remaining_ms, want.none_armed, want.last);
                            $display("dtq_checker: got kind %0d timer %0d rem %0d none %0b last %0b",
                                     i_out_data.result_kind, i_out_data.result_timer,
                                     i_out_data.remaining_ms, i_out_data.none_armed,
                                     i_out_data.last);
                        end
                    end
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= due_results.size();
        o_results <= seen_results;
        o_expired <= seen_expired;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives commands and lazy window writes into the deadline timer queue with
// random idling on command and result channels; the checker gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtq_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    t_in_item          in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b1;
    t_out_item         out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LAZY_W-1:0] cfg_data = '0;

    int errors;
    int pending;
    int results;
    int expired;

    bit               tx_gaps = 1'b0;
    bit               rx_gaps = 1'b0;
    bit               hold_req = 1'b0;
    int               hold_len = 0;
    int               holds_done = 0;
    logic [VAL_W-1:0] clock_ms = '0;
    int               cmd_count [4];
    int               lazy_writes = 0;

    deadline_timer_queue_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    dtq_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_expired   (expired)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #16_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Result side: random stall bursts, or one long hold when requested.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                out_ready <= 1'b1;
                hold_req = 1'b0;
                holds_done++;
            end else if (rx_gaps && $urandom_range(0, 9) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Valid stays high after a beat; the next call either reuses it or drops it
    // for a gap, so valid is never lowered and raised in the same step.
    task automatic send(input t_cmd cmd, input logic [ID_W-1:0] id,
                        input logic [VAL_W-1:0] val);
        t_in_item item;
        item.command  = cmd;
        item.timer_id = id;
        item.value    = val;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (cmd == CMD_TICK) clock_ms = val;
        cmd_count[cmd]++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_lazy(input logic [LAZY_W-1:0] window);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= window;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        lazy_writes++;
    endtask

    task automatic random_item();
        int               pick;
        logic [VAL_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            v = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3000);
            send(CMD_ARM, ID_W'($urandom_range(0, 15)), v);
        end else if (pick < 55) begin
            send(CMD_DISARM, ID_W'($urandom_range(0, 15)), $urandom);
        end else if (pick < 70) begin
            send(CMD_QUERY, ID_W'($urandom_range(0, 15)), $urandom);
        end else begin
            v = ($urandom_range(0, 9) == 0) ? $urandom : clock_ms + $urandom_range(0, 1500);
            send(CMD_TICK, ID_W'($urandom_range(0, 15)), v);
        end
    endtask

    initial begin
        logic [LAZY_W-1:0] phase_lazy [6];
        foreach (cmd_count[i]) cmd_count[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset window of 300 ms.
        send(CMD_QUERY, 0, 0);
        send(CMD_ARM, 0, 100);
        send(CMD_ARM, 15, 100);
        send(CMD_ARM, 5, 100);
        send(CMD_ARM, 7, 50);
        send(CMD_ARM, 3, 0);
        send(CMD_QUERY, 0, 0);
        send(CMD_ARM, 0, 399);              // just inside the window
        send(CMD_ARM, 0, 400);              // exactly on the window edge
        send(CMD_DISARM, 9, 0);             // slot that was never armed
        send(CMD_DISARM, 7, 0);
        send(CMD_TICK, 0, 100);             // equal deadlines go lower slot first
        send(CMD_QUERY, 0, 0);
        send(CMD_ARM, 1, 32'hFFFF_FFFF);    // lands one ms behind now
        send(CMD_ARM, 2, 32'h7FFF_FFFF);
        send(CMD_QUERY, 0, 0);
        send(CMD_ARM, 0, 32'h7FFF_FFFF);
        send(CMD_TICK, 15, 32'hFFFF_FF00);
        send(CMD_ARM, 4, 32'h0000_0200);    // deadline wraps past zero
        send(CMD_QUERY, 0, 0);
        send(CMD_TICK, 0, 32'h0000_0300);
        send(CMD_DISARM, 15, 32'hFFFF_FFFF);
        send(CMD_QUERY, 15, 32'hFFFF_FFFF);

        // A zero window never skips; then every slot expires on one tick.
        set_lazy('0);
        send(CMD_ARM, 6, 10);
        send(CMD_ARM, 6, 10);
        for (int s = 0; s < NUM_TIMERS_DEF; s++)
            send(CMD_ARM, ID_W'(s), $urandom_range(0, 20));
        send(CMD_TICK, 0, clock_ms + 50);

        set_lazy('1);
        send(CMD_ARM, 6, 1000);
        send(CMD_ARM, 6, 1000 + 65534);
        send(CMD_ARM, 6, 1000 + 65535);

        phase_lazy = '{16'hFFFF, 16'd1, 16'd0, 16'd300, 16'd0, 16'd2000};
        phase_lazy[2] = LAZY_W'($urandom);
        phase_lazy[4] = LAZY_W'($urandom);
        for (int p = 0; p < 6; p++) begin
            set_lazy(phase_lazy[p]);
            tx_gaps = (p == 0) || (p < 5 && $urandom_range(0, 1) == 1);
            rx_gaps = (p == 0) || (p < 5 && $urandom_range(0, 1) == 1);
            if (p == 2) begin
                // Results back up while commands keep coming.
                tx_gaps = 1'b0;
                hold_len = 400;
                hold_req = 1'b1;
            end
            for (int n = 0; n < 45; n++) begin
                if (p == 3 && n == 20) settle();
                random_item();
            end
        end

        settle();
        repeat (64) @(posedge clk);
        $display("Sent %0d commands: %0d ticks, %0d arms, %0d disarms, %0d queries.",
                 cmd_count[CMD_TICK] + cmd_count[CMD_ARM] + cmd_count[CMD_DISARM]
                 + cmd_count[CMD_QUERY], cmd_count[CMD_TICK], cmd_count[CMD_ARM],
                 cmd_count[CMD_DISARM], cmd_count[CMD_QUERY]);
        $display("Checked %0d results (%0d expiries) over %0d window settings, %0d long hold.",
                 results, expired, lazy_writes, holds_done);
        if (errors == 0 && pending == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
